// ===== design/tga_pkg.sv =====
package tga_pkg;

	localparam int DIM_W       = 16;
	localparam int CNT_W       = 8;
	localparam int HIDX_W      = 5;
	localparam int PIXELS_W    = 2 * DIM_W;
	localparam int TOTAL_W     = DIM_W + 1;
	localparam int QUOT_W      = 8;
	localparam int DSH_W       = DIM_W + QUOT_W - 1;
	localparam int STEP_CNT_W  = $clog2(QUOT_W + 1);
	localparam int DIV_STEPS   = 3;

	localparam logic [HIDX_W-1:0] HDR_ID_LEN     = 5'd0;
	localparam logic [HIDX_W-1:0] HDR_CMAP_TYPE  = 5'd1;
	localparam logic [HIDX_W-1:0] HDR_IMG_TYPE   = 5'd2;
	localparam logic [HIDX_W-1:0] HDR_WIDTH_LO   = 5'd12;
	localparam logic [HIDX_W-1:0] HDR_WIDTH_HI   = 5'd13;
	localparam logic [HIDX_W-1:0] HDR_HEIGHT_LO  = 5'd14;
	localparam logic [HIDX_W-1:0] HDR_HEIGHT_HI  = 5'd15;
	localparam logic [HIDX_W-1:0] HDR_DEPTH      = 5'd16;
	localparam logic [HIDX_W-1:0] HDR_LAST       = 5'd17;

	localparam logic [7:0] TYPE_RAW     = 8'd2;
	localparam logic [7:0] TYPE_RLE     = 8'd10;
	localparam logic [7:0] DEPTH_24     = 8'd24;
	localparam logic [7:0] DEPTH_32     = 8'd32;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0] PKT_COUNT_MASK = 8'h7f;
	localparam int         PKT_RUN_BIT  = 7;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_IDSKIP,
		PH_PACKET,
		PH_PIXEL,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_PIXEL      = 2'd0,
		ST_BAD_TYPE   = 2'd1,
		ST_BAD_FORMAT = 2'd2
	} status_t;

	typedef struct packed {
		status_t          status;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [7:0]       alpha;
		logic [DIM_W-1:0] start_row;
		logic [DIM_W-1:0] start_column;
		logic [CNT_W-1:0] run_count;
		logic             last_run;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
	} res_t;

	typedef struct packed {
		logic               start;
		logic [TOTAL_W-1:0] total;
		logic [DIM_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [QUOT_W-1:0] quot;
		logic [DIM_W-1:0]  rem;
	} div_rsp_t;

endpackage

// ===== design/tga_rle_image_decoder.sv =====
// channel  handshake             payload
// in       in_valid / in_stall   data_byte, file_start
// out      out_valid / out_stall status, red, green, blue, alpha, start_row,
//                                start_column, run_count, last_run,
//                                image_width, image_height
//
// One byte per cycle while in_stall stays low; a byte is held in the input
// register and its result in the output register. A run packet's position
// update goes through a restoring divider (three quotient bits a cycle) that
// always finishes before the next pixel of the file can need it.
// Reset puts the parser in the header phase with an empty output register.
// out_stall holds the result; the input register keeps taking bytes until
// a byte that makes a result finds the output register still full.
module tga_rle_image_decoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                data_byte,
	input  logic                      file_start,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [7:0]                red,
	output logic [7:0]                green,
	output logic [7:0]                blue,
	output logic [7:0]                alpha,
	output logic [tga_pkg::DIM_W-1:0] start_row,
	output logic [tga_pkg::DIM_W-1:0] start_column,
	output logic [tga_pkg::CNT_W-1:0] run_count,
	output logic                      last_run,
	output logic [tga_pkg::DIM_W-1:0] image_width,
	output logic [tga_pkg::DIM_W-1:0] image_height
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              start_s1;
	logic              take, res_load, out_free;
	tga_pkg::res_t     res_d, res_out;
	tga_pkg::div_req_t div_req;
	tga_pkg::div_rsp_t div_rsp;

	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= data_byte;
			start_s1 <= file_start;
		end
	end

	tga_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.data_byte  (byte_s1),
		.file_start (start_s1),
		.out_free   (out_free),
		.div_rsp    (div_rsp),
		.div_req    (div_req),
		.take       (take),
		.res_load   (res_load),
		.res        (res_d)
	);

	tga_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tga_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_load),
		.d      (res_d),
		.stall  (out_stall),
		.valid  (out_valid),
		.free   (out_free),
		.q      (res_out)
	);

	assign status       = res_out.status;
	assign red          = res_out.red;
	assign green        = res_out.green;
	assign blue         = res_out.blue;
	assign alpha        = res_out.alpha;
	assign start_row    = res_out.start_row;
	assign start_column = res_out.start_column;
	assign run_count    = res_out.run_count;
	assign last_run     = res_out.last_run;
	assign image_width  = res_out.image_width;
	assign image_height = res_out.image_height;

endmodule

// ===== design/tga_div.sv =====
module tga_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tga_pkg::div_req_t req,
	output tga_pkg::div_rsp_t rsp
);

	localparam logic [tga_pkg::STEP_CNT_W-1:0] QUOT_STEPS =
		tga_pkg::STEP_CNT_W'(tga_pkg::QUOT_W);

	logic                             busy_q;
	logic [tga_pkg::STEP_CNT_W-1:0]   cnt_q;
	logic [tga_pkg::TOTAL_W-1:0]      rem_q;
	logic [tga_pkg::DSH_W-1:0]        dsh_q;
	logic [tga_pkg::QUOT_W-1:0]       quot_q;

	logic [tga_pkg::STEP_CNT_W-1:0]   c;
	logic [tga_pkg::TOTAL_W-1:0]      r;
	logic [tga_pkg::DSH_W-1:0]        d;
	logic [tga_pkg::QUOT_W-1:0]       q;

	// restoring division, a few quotient bits per cycle, MSB first
	always_comb begin
		c = cnt_q;
		r = rem_q;
		d = dsh_q;
		q = quot_q;
		for (int j = 0; j < tga_pkg::DIV_STEPS; j++) begin
			if (c != '0) begin
				if ({{(tga_pkg::DSH_W - tga_pkg::TOTAL_W){1'b0}}, r} >= d) begin
					r = r - d[tga_pkg::TOTAL_W-1:0];
					q = {q[tga_pkg::QUOT_W-2:0], 1'b1};
				end else begin
					q = {q[tga_pkg::QUOT_W-2:0], 1'b0};
				end
				d = d >> 1;
				c = c - 1'b1;
			end
		end
		rsp.busy = busy_q;
		rsp.done = busy_q && (c == '0);
		rsp.quot = q;
		rsp.rem  = r[tga_pkg::DIM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= QUOT_STEPS;
		end else if (busy_q) begin
			cnt_q <= c;
			if (c == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.total;
			dsh_q  <= {req.divisor, {(tga_pkg::QUOT_W - 1){1'b0}}};
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= r;
			dsh_q  <= d;
			quot_q <= q;
		end
	end

endmodule

// ===== design/tga_parse.sv =====
module tga_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic [7:0]        data_byte,
	input  logic              file_start,
	input  logic              out_free,
	input  tga_pkg::div_rsp_t div_rsp,
	output tga_pkg::div_req_t div_req,
	output logic              take,
	output logic              res_load,
	output tga_pkg::res_t     res
);

	tga_pkg::phase_t              phase_q, phase_n, eff_phase, data_ph;
	tga_pkg::status_t             err_q, err_n, eff_err;
	logic [tga_pkg::HIDX_W-1:0]   hidx_q, hidx_n, eff_idx;
	logic [7:0]                   low_q, low_n;
	logic [7:0]                   idskip_q, idskip_n;
	logic                         rle_q, rle_n;
	logic                         four_q, four_n;
	logic [tga_pkg::DIM_W-1:0]    width_q, width_n;
	logic [tga_pkg::DIM_W-1:0]    height_q, height_n;
	logic [tga_pkg::DIM_W-1:0]    row_q, row_n;
	logic [tga_pkg::DIM_W-1:0]    col_q, col_n;
	logic [tga_pkg::CNT_W-1:0]    pleft_q, pleft_n;
	logic                         prun_q, prun_n;
	logic [1:0]                   pbi_q, pbi_n, lastb;
	logic [7:0]                   blue_q, blue_n;
	logic [7:0]                   green_q, green_n;
	logic [7:0]                   red_q, red_n;
	logic [tga_pkg::PIXELS_W-1:0] pixleft_q, pixleft_n, area, n_wide;
	logic [tga_pkg::CNT_W-1:0]    n;
	logic                         is_run, res_v, div_go, pos_wait;

	assign area   = width_q * height_q;
	assign lastb  = four_q ? 2'd3 : 2'd2;
	assign is_run = rle_q && prun_q;
	assign n      = is_run ? pleft_q : tga_pkg::CNT_W'(1);
	assign n_wide = {{(tga_pkg::PIXELS_W - tga_pkg::CNT_W){1'b0}}, n};

	always_comb begin
		eff_phase = file_start ? tga_pkg::PH_HEADER : phase_q;
		eff_idx   = file_start ? '0 : hidx_q;
		eff_err   = file_start ? tga_pkg::ST_PIXEL : err_q;
		data_ph   = rle_q ? tga_pkg::PH_PACKET : tga_pkg::PH_PIXEL;

		phase_n   = eff_phase;
		hidx_n    = eff_idx;
		err_n     = eff_err;
		low_n     = low_q;
		idskip_n  = idskip_q;
		rle_n     = rle_q;
		four_n    = four_q;
		width_n   = width_q;
		height_n  = height_q;
		row_n     = row_q;
		col_n     = col_q;
		pleft_n   = pleft_q;
		prun_n    = prun_q;
		pbi_n     = pbi_q;
		blue_n    = blue_q;
		green_n   = green_q;
		red_n     = red_q;
		pixleft_n = pixleft_q;

		res_v = 1'b0;
		div_go = 1'b0;
		res = '0;
		res.status       = tga_pkg::ST_PIXEL;
		res.image_width  = width_q;
		res.image_height = height_q;

		unique case (eff_phase)
			tga_pkg::PH_HEADER: begin
				if (eff_idx < tga_pkg::HDR_LAST) begin
					unique case (eff_idx)
						tga_pkg::HDR_ID_LEN: idskip_n = data_byte;
						tga_pkg::HDR_CMAP_TYPE: begin
							if (data_byte != 8'd0) err_n = tga_pkg::ST_BAD_FORMAT;
						end
						tga_pkg::HDR_IMG_TYPE: begin
							rle_n = (data_byte == tga_pkg::TYPE_RLE);
							if (data_byte != tga_pkg::TYPE_RAW && data_byte != tga_pkg::TYPE_RLE)
								err_n = tga_pkg::ST_BAD_TYPE;
						end
						tga_pkg::HDR_WIDTH_LO,
						tga_pkg::HDR_HEIGHT_LO: low_n = data_byte;
						tga_pkg::HDR_WIDTH_HI: width_n = {data_byte, low_q};
						tga_pkg::HDR_HEIGHT_HI: height_n = {data_byte, low_q};
						tga_pkg::HDR_DEPTH: begin
							four_n = (data_byte == tga_pkg::DEPTH_32);
							if (data_byte != tga_pkg::DEPTH_24 && data_byte != tga_pkg::DEPTH_32
								&& eff_err == tga_pkg::ST_PIXEL)
								err_n = tga_pkg::ST_BAD_FORMAT;
						end
						default: ;
					endcase
					hidx_n = eff_idx + 1'b1;
				end else if (eff_err != tga_pkg::ST_PIXEL) begin
					res_v = 1'b1;
					res.status = eff_err;
					res.last_run = 1'b1;
					phase_n = tga_pkg::PH_DONE;
				end else if (width_q == '0 || height_q == '0) begin
					res_v = 1'b1;
					res.last_run = 1'b1;
					phase_n = tga_pkg::PH_DONE;
				end else begin
					row_n     = height_q - 1'b1;
					col_n     = '0;
					pleft_n   = '0;
					prun_n    = 1'b0;
					pbi_n     = '0;
					pixleft_n = area;
					phase_n   = (idskip_q != 8'd0) ? tga_pkg::PH_IDSKIP : data_ph;
				end
			end
			tga_pkg::PH_IDSKIP: begin
				idskip_n = idskip_q - 1'b1;
				if (idskip_n == 8'd0) phase_n = data_ph;
			end
			tga_pkg::PH_PACKET: begin
				pleft_n = (data_byte & tga_pkg::PKT_COUNT_MASK) + 1'b1;
				prun_n  = data_byte[tga_pkg::PKT_RUN_BIT];
				pbi_n   = '0;
				phase_n = tga_pkg::PH_PIXEL;
			end
			tga_pkg::PH_PIXEL: begin
				if (pbi_q < lastb) begin
					unique case (pbi_q)
						2'd0: blue_n = data_byte;
						2'd1: green_n = data_byte;
						default: red_n = data_byte;
					endcase
					pbi_n = pbi_q + 1'b1;
				end else begin
					pbi_n = '0;
					res_v = 1'b1;
					res.red          = four_q ? red_q : data_byte;
					res.alpha        = four_q ? data_byte : tga_pkg::ALPHA_OPAQUE;
					res.green        = green_q;
					res.blue         = blue_q;
					res.start_row    = row_q;
					res.start_column = col_q;
					if (n_wide >= pixleft_q) begin
						// clip at the image end
						res.run_count = pixleft_q[tga_pkg::CNT_W-1:0];
						res.last_run  = 1'b1;
						phase_n = tga_pkg::PH_DONE;
					end else begin
						res.run_count = n;
						pixleft_n = pixleft_q - n_wide;
						if (is_run) begin
							div_go = 1'b1;
						end else if (col_q + 1'b1 == width_q) begin
							col_n = '0;
							row_n = row_q - 1'b1;
						end else begin
							col_n = col_q + 1'b1;
						end
						if (rle_q) begin
							pleft_n = is_run ? '0 : pleft_q - 1'b1;
							if (pleft_n == '0) phase_n = tga_pkg::PH_PACKET;
						end
					end
				end
			end
			tga_pkg::PH_DONE: ;
			default: ;
		endcase
	end

	// hold a pixel's last byte while a run's position update is still in the divider
	assign pos_wait = div_rsp.busy && (eff_phase == tga_pkg::PH_PIXEL) && (pbi_q == lastb);
	assign take     = item_valid && !pos_wait && (!res_v || out_free);
	assign res_load = take && res_v;

	assign div_req.start   = take && div_go;
	assign div_req.total   = {1'b0, col_q} + {{(tga_pkg::TOTAL_W - tga_pkg::CNT_W){1'b0}}, n};
	assign div_req.divisor = width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= tga_pkg::PH_HEADER;
			err_q     <= tga_pkg::ST_PIXEL;
			hidx_q    <= '0;
			low_q     <= '0;
			idskip_q  <= '0;
			rle_q     <= 1'b0;
			four_q    <= 1'b0;
			width_q   <= '0;
			height_q  <= '0;
			row_q     <= '0;
			col_q     <= '0;
			pleft_q   <= '0;
			prun_q    <= 1'b0;
			pbi_q     <= '0;
			blue_q    <= '0;
			green_q   <= '0;
			red_q     <= '0;
			pixleft_q <= '0;
		end else begin
			if (take) begin
				phase_q   <= phase_n;
				err_q     <= err_n;
				hidx_q    <= hidx_n;
				low_q     <= low_n;
				idskip_q  <= idskip_n;
				rle_q     <= rle_n;
				four_q    <= four_n;
				width_q   <= width_n;
				height_q  <= height_n;
				pleft_q   <= pleft_n;
				prun_q    <= prun_n;
				pbi_q     <= pbi_n;
				blue_q    <= blue_n;
				green_q   <= green_n;
				red_q     <= red_n;
				pixleft_q <= pixleft_n;
			end
			// no byte taken while the divider finishes moves the position
			if (div_rsp.done) begin
				row_q <= row_q - {{(tga_pkg::DIM_W - tga_pkg::QUOT_W){1'b0}}, div_rsp.quot};
				col_q <= div_rsp.rem;
			end else if (take) begin
				row_q <= row_n;
				col_q <= col_n;
			end
		end
	end

endmodule

// ===== design/tga_out_reg.sv =====
module tga_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  tga_pkg::res_t d,
	input  logic          stall,
	output logic          valid,
	output logic          free,
	output tga_pkg::res_t q
);

	logic          valid_q;
	tga_pkg::res_t res_q;

	assign free  = !valid_q || !stall;
	assign valid = valid_q;
	assign q     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= d;
		end
	end

endmodule

// ===== bench/tga_decode_checker.sv =====
`timescale 1ns / 100ps

module tga_decode_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [7:0]                data_byte,
	input  logic                      file_start,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [1:0]                status,
	input  logic [7:0]                red,
	input  logic [7:0]                green,
	input  logic [7:0]                blue,
	input  logic [7:0]                alpha,
	input  logic [tga_pkg::DIM_W-1:0] start_row,
	input  logic [tga_pkg::DIM_W-1:0] start_column,
	input  logic [tga_pkg::CNT_W-1:0] run_count,
	input  logic                      last_run,
	input  logic [tga_pkg::DIM_W-1:0] image_width,
	input  logic [tga_pkg::DIM_W-1:0] image_height,
	output int                        mismatch_count,
	output int                        outstanding,
	output int                        results_seen,
	output int                        rejects_seen,
	output int                        long_runs
);
	import tga_pkg::*;

	// decoder state as the file stream has left it
	phase_t            parse_ph;
	logic [HIDX_W-1:0] hdr_idx;
	logic [7:0]        lo_hold;
	logic [7:0]        id_left;
	logic              rle;
	logic              four;
	logic [DIM_W-1:0]  img_w;
	logic [DIM_W-1:0]  img_h;
	logic [DIM_W-1:0]  row;
	logic [DIM_W-1:0]  col;
	logic [7:0]        pkt_left;
	logic              pkt_run;
	logic [1:0]        pix_idx;
	logic [7:0]        blue_h;
	logic [7:0]        green_h;
	logic [7:0]        red_h;
	status_t           err_code;

	res_t  expected_runs[$];
	res_t  want_r;
	res_t  next_r;
	string diffs;

	task automatic report(input string what);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("check: %s", what);
	endtask

	function automatic res_t make_result(input status_t st, input logic [7:0] r_v, g_v, b_v,
			a_v, input logic [DIM_W-1:0] row_v, col_v, input logic [CNT_W-1:0] cnt,
			input logic fin);
		res_t r;
		r.status       = st;
		r.red          = r_v;
		r.green        = g_v;
		r.blue         = b_v;
		r.alpha        = a_v;
		r.start_row    = row_v;
		r.start_column = col_v;
		r.run_count    = cnt;
		r.last_run     = fin;
		r.image_width  = img_w;
		r.image_height = img_h;
		return r;
	endfunction

	// advance the decoder by one file byte; returns 1 when a result is due
	function automatic logic decode_byte(input logic [7:0] b, input logic fs, output res_t r);
		logic [1:0]  last_idx;
		logic [7:0]  red_v;
		logic [7:0]  alpha_v;
		logic        is_run;
		logic [8:0]  n;
		logic [32:0] remaining;
		logic [16:0] total;
		r = '0;
		if (fs) begin
			parse_ph = PH_HEADER;
			hdr_idx  = '0;
			err_code = ST_PIXEL;
		end
		case (parse_ph)
			PH_HEADER: begin
				case (hdr_idx)
					HDR_ID_LEN:    id_left = b;
					HDR_CMAP_TYPE: if (b != 8'd0) err_code = ST_BAD_FORMAT;
					HDR_IMG_TYPE: begin
						rle = (b == TYPE_RLE);
						if (b != TYPE_RAW && b != TYPE_RLE)
							err_code = ST_BAD_TYPE;
					end
					HDR_WIDTH_LO, HDR_HEIGHT_LO: lo_hold = b;
					HDR_WIDTH_HI:  img_w = {b, lo_hold};
					HDR_HEIGHT_HI: img_h = {b, lo_hold};
					HDR_DEPTH: begin
						four = (b == DEPTH_32);
						if (b != DEPTH_24 && b != DEPTH_32 && err_code == ST_PIXEL)
							err_code = ST_BAD_FORMAT;
					end
					default: ;
				endcase
				if (hdr_idx < HDR_LAST) begin
					hdr_idx = hdr_idx + 1'b1;
					return 1'b0;
				end
				if (err_code != ST_PIXEL || img_w == '0 || img_h == '0) begin
					r = make_result(err_code, 8'd0, 8'd0, 8'd0, 8'd0, '0, '0, '0, 1'b1);
					parse_ph = PH_DONE;
					return 1'b1;
				end
				row      = img_h - 1'b1;
				col      = '0;
				pkt_left = 8'd0;
				pkt_run  = 1'b0;
				pix_idx  = 2'd0;
				if (id_left != 8'd0)
					parse_ph = PH_IDSKIP;
				else
					parse_ph = rle ? PH_PACKET : PH_PIXEL;
				return 1'b0;
			end
			PH_IDSKIP: begin
				id_left = id_left - 8'd1;
				if (id_left == 8'd0)
					parse_ph = rle ? PH_PACKET : PH_PIXEL;
				return 1'b0;
			end
			PH_PACKET: begin
				pkt_left = (b & PKT_COUNT_MASK) + 8'd1;
				pkt_run  = b[PKT_RUN_BIT];
				pix_idx  = 2'd0;
				parse_ph = PH_PIXEL;
				return 1'b0;
			end
			PH_PIXEL: begin
				last_idx = four ? 2'd3 : 2'd2;
				if (pix_idx < last_idx) begin
					case (pix_idx)
						2'd0:    blue_h = b;
						2'd1:    green_h = b;
						default: red_h = b;
					endcase
					pix_idx = pix_idx + 2'd1;
					return 1'b0;
				end
				pix_idx = 2'd0;
				red_v   = four ? red_h : b;
				alpha_v = four ? b : ALPHA_OPAQUE;
				if (img_w == '0) begin
					parse_ph = PH_DONE;
					return 1'b0;
				end
				is_run    = rle && pkt_run;
				n         = is_run ? {1'b0, pkt_left} : 9'd1;
				remaining = {17'd0, row} * {17'd0, img_w} + {17'd0, img_w - col};
				// clip at the image end
				if (n >= remaining) begin
					r = make_result(ST_PIXEL, red_v, green_h, blue_h, alpha_v, row, col,
						remaining[7:0], 1'b1);
					parse_ph = PH_DONE;
					return 1'b1;
				end
				r = make_result(ST_PIXEL, red_v, green_h, blue_h, alpha_v, row, col,
					n[7:0], 1'b0);
				total = {1'b0, col} + {8'd0, n};
				row   = row - DIM_W'(total / img_w);
				col   = DIM_W'(total % img_w);
				if (rle) begin
					pkt_left = is_run ? 8'd0 : pkt_left - 8'd1;
					if (pkt_left == 8'd0)
						parse_ph = PH_PACKET;
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_ph = PH_HEADER;
			hdr_idx  = '0;
			lo_hold  = 8'd0;
			id_left  = 8'd0;
			rle      = 1'b0;
			four     = 1'b0;
			img_w    = '0;
			img_h    = '0;
			row      = '0;
			col      = '0;
			pkt_left = 8'd0;
			pkt_run  = 1'b0;
			pix_idx  = 2'd0;
			blue_h   = 8'd0;
			green_h  = 8'd0;
			red_h    = 8'd0;
			err_code = ST_PIXEL;
			expected_runs.delete();
			mismatch_count = 0;
			outstanding    = 0;
			results_seen   = 0;
			rejects_seen   = 0;
			long_runs      = 0;
		end else begin
			// a result never leaves in the cycle its byte arrives, so check before predicting
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_runs.size() == 0) begin
					report($sformatf("result %0d with none expected: status %0d row %0d column %0d",
						results_seen, status, start_row, start_column));
				end else begin
					want_r = expected_runs.pop_front();
					diffs  = "";
					if (status !== want_r.status)
						diffs = {diffs, $sformatf(" status %0d/%0d", status, want_r.status)};
					if (red !== want_r.red)
						diffs = {diffs, $sformatf(" red %0d/%0d", red, want_r.red)};
					if (green !== want_r.green)
						diffs = {diffs, $sformatf(" green %0d/%0d", green, want_r.green)};
					if (blue !== want_r.blue)
						diffs = {diffs, $sformatf(" blue %0d/%0d", blue, want_r.blue)};
					if (alpha !== want_r.alpha)
						diffs = {diffs, $sformatf(" alpha %0d/%0d", alpha, want_r.alpha)};
					if (start_row !== want_r.start_row)
						diffs = {diffs, $sformatf(" row %0d/%0d", start_row, want_r.start_row)};
					if (start_column !== want_r.start_column)
						diffs = {diffs, $sformatf(" column %0d/%0d", start_column,
							want_r.start_column)};
					if (run_count !== want_r.run_count)
						diffs = {diffs, $sformatf(" count %0d/%0d", run_count, want_r.run_count)};
					if (last_run !== want_r.last_run)
						diffs = {diffs, $sformatf(" last %0d/%0d", last_run, want_r.last_run)};
					if (image_width !== want_r.image_width)
						diffs = {diffs, $sformatf(" width %0d/%0d", image_width,
							want_r.image_width)};
					if (image_height !== want_r.image_height)
						diffs = {diffs, $sformatf(" height %0d/%0d", image_height,
							want_r.image_height)};
					if (diffs != "")
						report($sformatf("result %0d got/expected:%s", results_seen, diffs));
					if (want_r.status != ST_PIXEL)
						rejects_seen++;
					if (want_r.run_count == 8'd128)
						long_runs++;
				end
			end
			if (in_valid && !in_stall) begin
				if (decode_byte(data_byte, file_start, next_r))
					expected_runs.push_back(next_r);
			end
			outstanding = expected_runs.size();
		end
	end

endmodule

// ===== bench/tb_tga_rle_image_decoder.sv =====
`timescale 1ns / 100ps

module tb_tga_rle_image_decoder;
	import tga_pkg::*;

	typedef enum int {
		IMG_RAW,
		IMG_RLE,
		IMG_BAD_TYPE,
		IMG_BAD_FORMAT,
		IMG_EMPTY,
		IMG_HUGE
	} image_kind_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        data_byte = 8'd0;
	logic              file_start = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        status;
	logic [7:0]        red;
	logic [7:0]        green;
	logic [7:0]        blue;
	logic [7:0]        alpha;
	logic [DIM_W-1:0]  start_row;
	logic [DIM_W-1:0]  start_column;
	logic [CNT_W-1:0]  run_count;
	logic              last_run;
	logic [DIM_W-1:0]  image_width;
	logic [DIM_W-1:0]  image_height;

	int mismatch_count;
	int outstanding;
	int results_seen;
	int rejects_seen;
	int long_runs;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int bytes_sent = 0;
	int files_sent = 0;

	logic [7:0] file_q[$];

	tga_rle_image_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .file_start(file_start),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .red(red), .green(green), .blue(blue), .alpha(alpha),
		.start_row(start_row), .start_column(start_column), .run_count(run_count),
		.last_run(last_run), .image_width(image_width), .image_height(image_height)
	);

	tga_decode_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .file_start(file_start),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .red(red), .green(green), .blue(blue), .alpha(alpha),
		.start_row(start_row), .start_column(start_column), .run_count(run_count),
		.last_run(last_run), .image_width(image_width), .image_height(image_height),
		.mismatch_count(mismatch_count), .outstanding(outstanding),
		.results_seen(results_seen), .rejects_seen(rejects_seen), .long_runs(long_runs)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	function automatic logic [15:0] pick_extent();
		case ($urandom_range(2))
			0:       return 16'd1;
			1:       return 16'hffff;
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic image_kind_t pick_kind();
		int roll;
		roll = $urandom_range(99);
		if (roll < 30)
			return IMG_RAW;
		else if (roll < 70)
			return IMG_RLE;
		else if (roll < 77)
			return IMG_BAD_TYPE;
		else if (roll < 84)
			return IMG_BAD_FORMAT;
		else if (roll < 90)
			return IMG_EMPTY;
		return IMG_HUGE;
	endfunction

	task automatic push_header(input logic [7:0] id_len, cmap, img_type, input logic [15:0] w,
			h, input logic [7:0] depth);
		file_q.push_back(id_len);
		file_q.push_back(cmap);
		file_q.push_back(img_type);
		// colour map spec and origins are don't-care
		repeat (9) file_q.push_back(8'($urandom));
		file_q.push_back(w[7:0]);
		file_q.push_back(w[15:8]);
		file_q.push_back(h[7:0]);
		file_q.push_back(h[15:8]);
		file_q.push_back(depth);
		file_q.push_back(8'($urandom));
		repeat (id_len) file_q.push_back(8'($urandom));
	endtask

	task automatic build_file(input image_kind_t kind);
		logic [7:0]  id_len;
		logic [7:0]  cmap;
		logic [7:0]  img_type;
		logic [7:0]  depth;
		logic [15:0] w;
		logic [15:0] h;
		longint      pixels_left;
		int          bpp;
		int          cnt;
		int          roll;
		logic        run_pkt;
		file_q.delete();
		roll = $urandom_range(99);
		if (roll < 65)
			id_len = 8'd0;
		else if (roll < 96)
			id_len = 8'($urandom_range(1, 6));
		else
			id_len = 8'($urandom_range(7, 255));
		cmap     = 8'd0;
		img_type = $urandom_range(1) ? TYPE_RLE : TYPE_RAW;
		depth    = $urandom_range(1) ? DEPTH_32 : DEPTH_24;
		w        = 16'($urandom_range(1, 10));
		h        = 16'($urandom_range(1, 6));
		case (kind)
			IMG_RAW: img_type = TYPE_RAW;
			IMG_RLE: begin
				img_type = TYPE_RLE;
				w        = 16'($urandom_range(1, 40));
			end
			IMG_BAD_TYPE: begin
				do img_type = 8'($urandom);
				while (img_type == TYPE_RAW || img_type == TYPE_RLE);
				if ($urandom_range(1))
					cmap = 8'($urandom_range(1, 255));
			end
			IMG_BAD_FORMAT: begin
				if ($urandom_range(2) != 0)
					cmap = 8'($urandom_range(1, 255));
				if ($urandom_range(2) != 0) begin
					do depth = 8'($urandom);
					while (depth == DEPTH_24 || depth == DEPTH_32);
				end
				if (cmap == 8'd0 && (depth == DEPTH_24 || depth == DEPTH_32))
					depth = 8'd16;
			end
			IMG_EMPTY: begin
				w = pick_extent();
				h = pick_extent();
				case ($urandom_range(2))
					0:       w = 16'd0;
					1:       h = 16'd0;
					default: begin
						w = 16'd0;
						h = 16'd0;
					end
				endcase
			end
			default: begin
				w = pick_extent();
				h = pick_extent();
			end
		endcase
		push_header(id_len, cmap, img_type, w, h, depth);
		if (kind == IMG_BAD_TYPE || kind == IMG_BAD_FORMAT || kind == IMG_EMPTY) begin
			repeat ($urandom_range(4)) file_q.push_back(8'($urandom));
			return;
		end
		bpp         = (depth == DEPTH_32) ? 4 : 3;
		pixels_left = longint'(w) * longint'(h);
		// huge images stop at 100 bytes unless finished sooner; the next file start cuts them off
		while (pixels_left > 0 && (kind != IMG_HUGE || file_q.size() < 100)) begin
			if (img_type == TYPE_RLE) begin
				run_pkt = $urandom_range(1);
				if (run_pkt)
					cnt = ($urandom_range(99) < 70) ? $urandom_range(1, 8) : $urandom_range(1, 128);
				else
					cnt = ($urandom_range(99) < 95) ? $urandom_range(1, 6) : $urandom_range(1, 128);
				file_q.push_back({run_pkt, 7'(cnt - 1)});
				repeat (run_pkt ? 1 : cnt) repeat (bpp) file_q.push_back(8'($urandom));
				pixels_left -= cnt;
			end else begin
				repeat (bpp) file_q.push_back(8'($urandom));
				pixels_left--;
			end
		end
		if (kind != IMG_HUGE)
			repeat ($urandom_range(3)) file_q.push_back(8'($urandom));
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fs);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		file_start <= fs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	// files sent with a start mark are sometimes cut short at a random byte
	task automatic send_file(input logic mark_start);
		int len;
		len = file_q.size();
		if (mark_start && $urandom_range(99) < 8)
			len = $urandom_range(1, file_q.size());
		for (int i = 0; i < len; i++)
			send_byte(file_q[i], mark_start && i == 0);
		files_sent++;
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int byte_goal);
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		while (bytes_sent < byte_goal) begin
			build_file(pick_kind());
			send_file(1'b1);
		end
		// hold off until every result of this phase is out
		in_valid <= 1'b0;
		do @(negedge clk);
		while (outstanding != 0);
		@(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_pct   = 24;
		sink_stall_pct = 47;
		// first file goes in with no start mark: one ID byte, one 24-bit pixel, one stray byte
		file_q.delete();
		push_header(8'd1, 8'd0, TYPE_RAW, 16'd1, 16'd1, DEPTH_24);
		file_q.push_back(8'hff);
		file_q.push_back(8'h00);
		file_q.push_back(8'h80);
		file_q.push_back(8'h5a);
		send_file(1'b0);
		for (int k = 0; k <= int'(IMG_HUGE); k++) begin
			build_file(image_kind_t'(k));
			send_file(1'b1);
		end
		run_phase(24, 47, 570);
		run_phase(47, 24, 1140);
		run_phase(0, 0, 1700);
		repeat (16) @(posedge clk);
		$display("covered %0d bytes in %0d files with both sides idling in turn and then neither;",
			bytes_sent, files_sent);
		$display("checked %0d results: %0d rejected headers, %0d runs of 128 pixels",
			results_seen, rejects_seen, long_runs);
		if (outstanding != 0)
			$display("%0d expected results never came out", outstanding);
		if (mismatch_count == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("timeout with %0d results still expected", outstanding);
		$display("tb: failure");
		$finish;
	end

endmodule
